/* src/bwcf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwcf_pkg
// shared types, register map and byte classification for the banned word
// count filter
// ----------------------------------------------------------------------------
package bwcf_pkg;

   localparam int MAX_SLOTS       = 6;
   localparam int MAX_WORD_BYTES  = 8;
   localparam int SLOT_W          = 64;
   localparam int LEN_W           = 4;   // holds 0..MAX_WORD_BYTES
   localparam int HITS_W          = 16;
   localparam int ACTIVE_W        = 3;
   localparam int INC_W           = 3;   // holds 0..MAX_SLOTS
   localparam int CSR_ADDR_W      = 6;
   localparam int CSR_DATA_W      = 64;
   localparam int REG_IDX_W       = 3;

   // register indexes, slots occupy indexes 0 .. MAX_SLOTS-1
   localparam logic [REG_IDX_W-1:0] REG_ACTIVE_SLOTS = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_ALLOWED_HITS = 3'd7;

   localparam logic [HITS_W-1:0] HITS_MAX = '1;

   // byte codes that end a word besides punctuation
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   typedef struct packed {
      logic [MAX_SLOTS-1:0][SLOT_W-1:0] slot;
      logic [ACTIVE_W-1:0]              active_slots;
      logic [HITS_W-1:0]                allowed_hits;
   } cfg_type;

   // space, newline and ascii punctuation
   function automatic logic is_separator(input logic [7:0] b);
      logic sep;
      sep = (b == CHAR_SPACE) || (b == CHAR_NEWLINE) ||
            (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
            (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
      return sep;
   endfunction

   // position of the highest nonzero byte plus one
   function automatic logic [LEN_W-1:0] slot_length(input logic [SLOT_W-1:0] v);
      logic [LEN_W-1:0] n;
      n = '0;
      for (int i = 0; i < MAX_WORD_BYTES; i++) begin
         if (v[8*i +: 8] != 8'h00) begin
            n = LEN_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

/* src/bwcf_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwcf_csr
// apb register file holding the banned word slots, slot count and hit limit
// ----------------------------------------------------------------------------
module bwcf_csr
   import bwcf_pkg::*;
#(
   parameter int SLOT_COUNT = MAX_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [SLOT_W-1:0]    slot_ff [SLOT_COUNT];
   logic [ACTIVE_W-1:0]  active_slots_ff;
   logic [HITS_W-1:0]    allowed_hits_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1 -: REG_IDX_W];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_slot
      always_ff @(posedge clock) begin
         if (reset) begin
            slot_ff[s] <= '0;
         end else if (wr_en && reg_idx == REG_IDX_W'(s)) begin
            slot_ff[s] <= csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_slots_ff <= '0;
         allowed_hits_ff <= '0;
      end else if (wr_en) begin
         if (reg_idx == REG_ACTIVE_SLOTS) begin
            active_slots_ff <= csr_pwdata[ACTIVE_W-1:0];
         end
         if (reg_idx == REG_ALLOWED_HITS) begin
            allowed_hits_ff <= csr_pwdata[HITS_W-1:0];
         end
      end
   end

   always_comb begin
      cfg.slot         = '0;
      cfg.active_slots = active_slots_ff;
      cfg.allowed_hits = allowed_hits_ff;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         cfg.slot[s] = slot_ff[s];
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_ACTIVE_SLOTS) begin
         csr_prdata = CSR_DATA_W'(active_slots_ff);
      end else if (reg_idx == REG_ALLOWED_HITS) begin
         csr_prdata = CSR_DATA_W'(allowed_hits_ff);
      end else begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            if (reg_idx == REG_IDX_W'(s)) begin
               csr_prdata = slot_ff[s];
            end
         end
      end
   end

endmodule

/* src/bwcf_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwcf_match
// compares one finished word with all active slots and counts equal ones
// ----------------------------------------------------------------------------
module bwcf_match
   import bwcf_pkg::*;
#(
   parameter int SLOT_COUNT = MAX_SLOTS
) (
   input  cfg_type           cfg,
   input  logic [SLOT_W-1:0] word,
   input  logic [LEN_W-1:0]  word_len,
   input  logic              word_ok,
   output logic [INC_W-1:0]  hit_inc
);

   logic [SLOT_COUNT-1:0] hit;

   for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_cmp
      assign hit[s] = word_ok &&
                      (ACTIVE_W'(s) < cfg.active_slots) &&
                      (cfg.slot[s] != '0) &&
                      (cfg.slot[s] == word) &&
                      (slot_length(cfg.slot[s]) == word_len);
   end

   always_comb begin
      hit_inc = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         hit_inc = hit_inc + INC_W'(hit[s]);
      end
   end

endmodule

/* src/banned_word_count_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banned_word_count_filter
// counts banned words in a byte stream and flags whether a message may go out
// ----------------------------------------------------------------------------
// datapath: a request byte is registered at the input and handled from there,
//   and a message result is registered in the result register and shown on rsp
// throughput: one byte per cycle; only a held result stalls a last byte
// reset: synchronous active high; clears valid flags, word state and count
// ----------------------------------------------------------------------------
module banned_word_count_filter
   import bwcf_pkg::*;
#(
   parameter int SLOT_COUNT = MAX_SLOTS,
   parameter int WORD_BYTES = MAX_WORD_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] text_byte
   input  logic                  req_tlast,   // end_of_message
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [15:0] hit_count, [16] sendable
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int STORE_W = 8 * WORD_BYTES;
   localparam int WLEN_W  = $clog2(WORD_BYTES + 1);

   cfg_type cfg;

   // input register
   logic              in_vld_ff,  in_vld_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;

   // word and count state
   logic [STORE_W-1:0] store_ff,    store_in;
   logic [WLEN_W-1:0]  len_ff,      len_in;
   logic               too_long_ff, too_long_in;
   logic [HITS_W-1:0]  hits_ff,     hits_in;

   // result register
   logic              rsp_vld_ff, rsp_vld_in;
   logic [HITS_W-1:0] rsp_hits_ff;
   logic              rsp_send_ff;

   logic               advance;
   logic               sep;
   logic               close;
   logic [STORE_W-1:0] app_store;
   logic [STORE_W-1:0] eff_store;
   logic [WLEN_W-1:0]  eff_len;
   logic               eff_long;
   logic               word_ok;
   logic [INC_W-1:0]   hit_inc;
   logic [HITS_W:0]    hits_sum;
   logic [HITS_W-1:0]  hits_new;

   bwcf_csr #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // the registered byte moves on unless it ends a message and the result
   // register is still full and not being taken
   assign advance    = in_vld_ff && (!in_last_ff || !rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tready) begin
         in_vld_in = req_tvalid;
      end
   end

   // byte classification
   assign sep   = is_separator(in_byte_ff);
   assign close = sep || in_last_ff;

   // word with the current byte placed at its position
   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         app_store[8*i +: 8] = (len_ff == WLEN_W'(i)) ? in_byte_ff : store_ff[8*i +: 8];
      end
   end

   // word as it stands after this byte, before any close
   always_comb begin
      if (sep) begin
         eff_store = store_ff;
         eff_len   = len_ff;
         eff_long  = too_long_ff;
      end else if (len_ff < WLEN_W'(WORD_BYTES)) begin
         eff_store = app_store;
         eff_len   = len_ff + WLEN_W'(1);
         eff_long  = too_long_ff;
      end else begin
         eff_store = store_ff;
         eff_len   = len_ff;
         eff_long  = 1'b1;
      end
   end

   // a word is compared only when it closes, is nonempty and fits
   assign word_ok = close && (eff_len != '0) && !eff_long;

   bwcf_match #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_match (
      .cfg      (cfg),
      .word     (SLOT_W'(eff_store)),
      .word_len (LEN_W'(eff_len)),
      .word_ok  (word_ok),
      .hit_inc  (hit_inc)
   );

   // saturating count update
   assign hits_sum = {1'b0, hits_ff} + (HITS_W + 1)'(hit_inc);
   assign hits_new = hits_sum[HITS_W] ? HITS_MAX : hits_sum[HITS_W-1:0];

   always_comb begin
      store_in    = store_ff;
      len_in      = len_ff;
      too_long_in = too_long_ff;
      hits_in     = hits_ff;
      if (advance) begin
         if (close) begin
            store_in    = '0;
            len_in      = '0;
            too_long_in = 1'b0;
         end else begin
            store_in    = eff_store;
            len_in      = eff_len;
            too_long_in = eff_long;
         end
         // message end hands the count to the result register and restarts
         hits_in = in_last_ff ? '0 : hits_new;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      if (advance && in_last_ff) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         store_ff    <= '0;
         len_ff      <= '0;
         too_long_ff <= 1'b0;
         hits_ff     <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         store_ff    <= store_in;
         len_ff      <= len_in;
         too_long_ff <= too_long_in;
         hits_ff     <= hits_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_hits_ff <= hits_new;
         rsp_send_ff <= (hits_new <= cfg.allowed_hits);
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'b0, rsp_send_ff, rsp_hits_ff};

endmodule
